@@ design/minv_pkg.sv @@
// ============================================================================
// minv_pkg
// Shared widths, defaults and controller/datapath interface types for the
// modular inverse unit.
// ============================================================================
package minv_pkg;

    // Fixed field widths of the stream items.
    localparam int VALUE_W       = 32;
    localparam int INV_W         = 33;
    localparam int M_TDATA_W     = 40;
    localparam int MOD_WIDTH_DEF = 33;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // Capture a new item and set up the first round.
        logic div_start;  // Clear the divider and product accumulator.
        logic div_step;   // One restoring division step with product update.
        logic update;     // Close a Euclid round.
        logic finish;     // Reduce the coefficient and capture the result.
    } t_minv_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rem_zero;   // The new remainder is zero, so the loop is over.
    } t_minv_sts;

endpackage

@@ design/minv_ctrl.sv @@
// ============================================================================
// minv_ctrl
// Controller for the modular inverse unit: sequences Euclid rounds, counts
// division steps and owns the handshake of both stream sides.
// ============================================================================
module minv_ctrl #(
    parameter int MOD_WIDTH = minv_pkg::MOD_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  minv_pkg::t_minv_sts i_sts,
    output minv_pkg::t_minv_cmd o_cmd
);
    import minv_pkg::*;

    localparam int RW    = (MOD_WIDTH > VALUE_W) ? MOD_WIDTH : VALUE_W;
    localparam int CNT_W = $clog2(RW + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CHECK  = 4'b0010,
        S_DIV    = 4'b0100,
        S_UPDATE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               w_out_free;
    logic               w_last_step;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_step = (r_cnt == CNT_W'(RW - 1));
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state, step counter and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.rem_zero) begin
                    o_cmd.div_start = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_DIV;
                end else if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (w_last_step) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result stays valid until the downstream side takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/minv_dp.sv @@
// ============================================================================
// minv_dp
// Datapath for the modular inverse unit: remainders, Bezout coefficients,
// a bit-serial restoring divider and a shift-add quotient product.
// ============================================================================
module minv_dp #(
    parameter int MOD_WIDTH = minv_pkg::MOD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  minv_pkg::t_minv_cmd            i_cmd,
    output minv_pkg::t_minv_sts            o_sts,
    input  logic [minv_pkg::VALUE_W-1:0]   i_value,
    input  logic [MOD_WIDTH-1:0]           i_modulus,
    output logic [minv_pkg::INV_W-1:0]     o_inverse,
    output logic                           o_not_invertible
);
    import minv_pkg::*;

    // Remainder width, and a signed coefficient width with headroom.
    localparam int RW       = (MOD_WIDTH > VALUE_W) ? MOD_WIDTH : VALUE_W;
    localparam int CW       = RW + 2;
    localparam int OUT_BITS = (MOD_WIDTH < INV_W) ? MOD_WIDTH : INV_W;
    localparam logic [INV_W-1:0] OUT_MASK = {INV_W{1'b1}} >> (INV_W - OUT_BITS);

    logic [RW-1:0]        r_rem_old, r_rem_new;
    logic [CW-1:0]        r_co_old, r_co_new;
    logic [MOD_WIDTH-1:0] r_n;
    logic [RW-1:0]        r_div_rem;
    logic [RW-1:0]        r_dvd;
    logic [CW-1:0]        r_prod;
    logic [INV_W-1:0]     r_inverse;
    logic                 r_not_inv;

    logic [RW:0]          w_trial;
    logic                 w_ge;
    logic [RW:0]          w_diff;
    logic [CW-1:0]        w_res;

    // One restoring division step: bring in the next dividend bit and
    // subtract the divisor when it fits.
    assign w_trial = {r_div_rem, r_dvd[RW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_rem_new});
    assign w_diff  = w_trial - {1'b0, r_rem_new};

    // Negative coefficient is brought into range by adding the modulus once.
    assign w_res = r_co_old[CW-1] ? (r_co_old + CW'(r_n)) : r_co_old;

    assign o_sts.rem_zero  = (r_rem_new == '0);
    assign o_inverse        = r_inverse;
    assign o_not_invertible = r_not_inv;

    // Round registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem_old <= RW'(i_modulus);
            r_rem_new <= RW'(i_value);
            r_co_old  <= '0;
            r_co_new  <= CW'(1);
            r_n       <= i_modulus;
        end else if (i_cmd.update) begin
            r_rem_old <= r_rem_new;
            r_rem_new <= r_div_rem;
            r_co_old  <= r_co_new;
            r_co_new  <= r_co_old - r_prod;
        end
    end

    // Divider and quotient-times-coefficient accumulator (MSB first Horner).
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_div_rem <= '0;
            r_dvd     <= r_rem_old;
            r_prod    <= '0;
        end else if (i_cmd.div_step) begin
            r_div_rem <= w_ge ? w_diff[RW-1:0] : w_trial[RW-1:0];
            r_dvd     <= {r_dvd[RW-2:0], 1'b0};
            r_prod    <= {r_prod[CW-2:0], 1'b0} + (w_ge ? r_co_new : '0);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_inverse <= w_res[INV_W-1:0] & OUT_MASK;
            r_not_inv <= (r_rem_old != RW'(1));
        end
    end

endmodule

@@ design/modular_inverse_ext_euclid_unit.sv @@
// ============================================================================
// modular_inverse_ext_euclid_unit
// Modular multiplicative inverse by the extended Euclidean algorithm.
//
// Channel   Dir  tdata (lowest bit up)                      tuser
// s_axis    in   value[31:0], modulus[MOD_WIDTH-1:0], pad  -
// m_axis    out  inverse[32:0], pad                        not_invertible
//
// One item is in work at a time. Each Euclid round runs a check, the division
// steps of the one-bit-per-cycle restoring divider and an update, with
// RW = max(MOD_WIDTH, 32) the remainder width. Reset is synchronous and
// active low and clears only the control state. A held result does not
// block the next item from entering; a finished item waits in the controller
// until the output register is free.
// ============================================================================
module modular_inverse_ext_euclid_unit #(
    parameter int MOD_WIDTH = minv_pkg::MOD_WIDTH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // Fields from bit 0: value (32), modulus (MOD_WIDTH), zero padding.
    input  logic [((minv_pkg::VALUE_W + MOD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // Fields from bit 0: inverse (33), zero padding.
    output logic [minv_pkg::M_TDATA_W-1:0]                m_axis_tdata,
    // Fields from bit 0: not_invertible (1).
    output logic                                          m_axis_tuser
);
    import minv_pkg::*;

    t_minv_cmd             w_cmd;
    t_minv_sts             w_sts;
    logic [VALUE_W-1:0]    w_value;
    logic [MOD_WIDTH-1:0]  w_modulus;
    logic [INV_W-1:0]      w_inverse;
    logic                  w_not_inv;

    // Unpack the input item.
    assign w_value   = s_axis_tdata[VALUE_W-1:0];
    assign w_modulus = s_axis_tdata[VALUE_W +: MOD_WIDTH];

    // Pack the result item.
    assign m_axis_tdata = {{(M_TDATA_W - INV_W){1'b0}}, w_inverse};
    assign m_axis_tuser = w_not_inv;

    // Sequencer.
    minv_ctrl #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic.
    minv_dp #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_value          (w_value),
        .i_modulus        (w_modulus),
        .o_inverse        (w_inverse),
        .o_not_invertible (w_not_inv)
    );

endmodule
